>>> rtl/core/dsr_pkg.sv
package dsr_pkg;

    // Sizes of the residue ring and the digit window.
    localparam int MAX_MODULUS = 128;
    localparam int IDX_W       = $clog2(MAX_MODULUS);
    localparam int WIN         = 10;
    localparam int STEP_W      = $clog2(MAX_MODULUS + WIN);

    // Field widths.
    localparam int CNT_W   = 30;
    localparam int CFG_W   = 8;
    localparam int DIGIT_W = 4;
    localparam int TC_W    = $clog2(WIN + 1);
    localparam int SUM_W   = 32;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

    // The counting prime and its double, at adder width.
    localparam logic [SUM_W-1:0] PRIME  = SUM_W'(1000000007);
    localparam logic [SUM_W-1:0] PRIME2 = SUM_W'(2000000014);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FINISH
    } state_t;

    // Control shared by the ring cells and the window.
    typedef struct packed {
        logic clear;
        logic shift;
    } ring_ctrl_t;

    // Brings a value below three times the prime back into range.
    function automatic logic [CNT_W-1:0] mod_reduce(input logic [SUM_W-1:0] x);
        logic [SUM_W-1:0] y;
        if (x >= PRIME2) begin
            y = x - PRIME2;
        end else if (x >= PRIME) begin
            y = x - PRIME;
        end else begin
            y = x;
        end
        return y[CNT_W-1:0];
    endfunction

endpackage

>>> rtl/core/dsr_cell.sv
module dsr_cell import dsr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  ring_ctrl_t       ctrl,
    input  logic             sel_feed,
    input  logic [CNT_W-1:0] neighbor_in,
    input  logic [CNT_W-1:0] feed_in,
    output logic [CNT_W-1:0] count_out
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // The cell at the end of the active ring takes the fed-back value.
    always_comb begin
        count_next = count_reg;
        if (ctrl.clear) begin
            count_next = '0;
        end else if (ctrl.shift) begin
            count_next = sel_feed ? feed_in : neighbor_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    assign count_out = count_reg;

endmodule

>>> rtl/core/dsr_window.sv
module dsr_window import dsr_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  ring_ctrl_t         ctrl,
    input  logic [CNT_W-1:0]   head_val,
    input  logic               head_tight,
    input  logic [DIGIT_W-1:0] digit,
    output logic [CNT_W-1:0]   next_val,
    output logic               moved_tight
);

    // Tap i holds the element streamed i+1 steps ago.
    logic [CNT_W-1:0] tap_val_reg   [WIN-1];
    logic [CNT_W-1:0] tap_val_next  [WIN-1];
    logic [WIN-2:0]   tap_tight_reg;
    logic [WIN-2:0]   tap_tight_next;
    logic [CNT_W-1:0] sum_reg;
    logic [CNT_W-1:0] sum_next;
    logic [WIN-1:0]   tbits;
    logic [TC_W-1:0]  tc;

    assign tbits = {tap_tight_reg, head_tight};

    // The tight prefix spreads only to the digits below the bound's digit.
    always_comb begin
        tc = '0;
        for (int i = 0; i < WIN; i++) begin
            if ((DIGIT_W'(i) < digit) && tbits[i]) begin
                tc = tc + TC_W'(1);
            end
        end
    end

    assign next_val    = mod_reduce({2'b00, sum_reg} + {2'b00, head_val} + SUM_W'(tc));
    assign moved_tight = tbits[digit];

    always_comb begin
        sum_next       = sum_reg;
        tap_val_next   = tap_val_reg;
        tap_tight_next = tap_tight_reg;
        if (ctrl.clear) begin
            sum_next       = '0;
            tap_tight_next = '0;
            for (int i = 0; i < WIN - 1; i++) begin
                tap_val_next[i] = '0;
            end
        end else if (ctrl.shift) begin
            sum_next = mod_reduce({2'b00, sum_reg} + {2'b00, head_val}
                                  + (PRIME - {2'b00, tap_val_reg[WIN-2]}));
            tap_val_next[0]   = head_val;
            tap_tight_next[0] = head_tight;
            for (int i = 1; i < WIN - 1; i++) begin
                tap_val_next[i]   = tap_val_reg[i-1];
                tap_tight_next[i] = tap_tight_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg       <= '0;
            tap_tight_reg <= '0;
            for (int i = 0; i < WIN - 1; i++) begin
                tap_val_reg[i] <= '0;
            end
        end else begin
            sum_reg       <= sum_next;
            tap_tight_reg <= tap_tight_next;
            tap_val_reg   <= tap_val_next;
        end
    end

    sum_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        {2'b00, sum_reg} < PRIME)
        else $error("window sum left the residue range");

endmodule

>>> rtl/core/digit_sum_residue_counter.sv
// Each digit request is accepted in the idle state, then runs one rotation of the residue
// ring plus nine priming steps of the window, then a finish state, which for a final digit
// waits for the result channel to be free and puts the count on it. A new digit request is
// taken only back in the idle state, after the previous one has finished.
// Reset: aresetn is synchronous and active low; it clears all counts, the tight residue
// and the result register, and sets the modulus to one.
module digit_sum_residue_counter import dsr_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    // Digit requests.
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [7:0]       s_tdata,    // [3:0] digit, [7:4] zero
    input  logic             s_tlast,    // last_digit
    // Results.
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [31:0]      m_tdata,    // [29:0] count, [31:30] zero
    // Modulus register.
    input  logic             cfg_wen,
    input  logic [CFG_W-1:0] cfg_wdata
);

    // The residue counts live in a ring of cells. Cell zero is the head; during
    // a digit the ring rotates once plus nine steps, and the window on the head
    // stream computes each new count from the ten counts ending at its index.
    // The head's residue index is tracked so the ring never needs realigning.

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   dm1_reg, dm1_next;        // effective modulus minus one
    logic [IDX_W-1:0]   tight_reg, tight_next;    // residue of the bound's prefix
    logic [IDX_W-1:0]   head_reg, head_next;      // residue index at cell zero
    logic [IDX_W-1:0]   newt_reg, newt_next;      // tight residue after this digit
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DIGIT_W-1:0] dig_reg, dig_next;
    logic               last_reg, last_next;
    logic [CNT_W-1:0]   res0_reg, res0_next;      // new count of residue zero
    logic [CNT_W-1:0]   out_reg, out_next;
    logic               mvalid_reg, mvalid_next;

    ring_ctrl_t         ring_ctrl;
    ring_ctrl_t         win_ctrl;
    logic [CNT_W-1:0]   cell_val [MAX_MODULUS];
    logic [CNT_W-1:0]   feed;
    logic [CNT_W-1:0]   head_val;
    logic [CNT_W-1:0]   next_val;
    logic               moved_tight;
    logic               producing;
    logic               step_end;
    logic               s_accept;
    logic [DIGIT_W-1:0] s_digit;
    logic [CNT_W-1:0]   final_count;

    assign head_val  = cell_val[0];
    assign s_accept  = s_tvalid && s_tready;
    assign s_digit   = (s_tdata[DIGIT_W-1:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[DIGIT_W-1:0];
    assign producing = (step_reg >= STEP_W'(WIN - 1));
    assign step_end  = (step_reg == STEP_W'(dm1_reg) + STEP_W'(WIN - 1));
    assign feed      = producing ? next_val : head_val;

    // Count of residue zero, plus one when the bound itself qualifies, minus
    // one for the number zero.
    assign final_count = mod_reduce({2'b00, res0_reg} + SUM_W'(newt_reg == '0)
                                    + (PRIME - SUM_W'(1)));

    always_comb begin
        state_next  = state_reg;
        dm1_next    = dm1_reg;
        tight_next  = tight_reg;
        head_next   = head_reg;
        newt_next   = newt_reg;
        step_next   = step_reg;
        dig_next    = dig_reg;
        last_next   = last_reg;
        res0_next   = res0_reg;
        out_next    = out_reg;
        mvalid_next = mvalid_reg;
        ring_ctrl   = '0;
        win_ctrl    = '0;
        s_tready    = 1'b0;

        if (mvalid_reg && m_tready) begin
            mvalid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_accept) begin
                    dig_next       = s_digit;
                    last_next      = s_tlast;
                    step_next      = '0;
                    newt_next      = tight_reg;
                    win_ctrl.clear = 1'b1;
                    state_next     = ST_RUN;
                end
            end
            ST_RUN: begin
                ring_ctrl.shift = 1'b1;
                win_ctrl.shift  = 1'b1;
                head_next = (head_reg == dm1_reg) ? '0 : head_reg + IDX_W'(1);
                step_next = step_reg + STEP_W'(1);
                if (producing && (head_reg == '0)) begin
                    res0_next = next_val;
                end
                if (producing && moved_tight) begin
                    newt_next = head_reg;
                end
                if (step_end) begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (!last_reg) begin
                    tight_next = newt_reg;
                    state_next = ST_IDLE;
                end else if (!mvalid_reg || m_tready) begin
                    out_next        = final_count;
                    mvalid_next     = 1'b1;
                    ring_ctrl.clear = 1'b1;
                    tight_next      = '0;
                    head_next       = '0;
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // A modulus write starts a new bound from empty counts.
        if (cfg_wen) begin
            if (cfg_wdata == '0) begin
                dm1_next = '0;
            end else if (int'(cfg_wdata) > MAX_MODULUS) begin
                dm1_next = IDX_W'(MAX_MODULUS - 1);
            end else begin
                dm1_next = IDX_W'(cfg_wdata - CFG_W'(1));
            end
            ring_ctrl.clear = 1'b1;
            tight_next      = '0;
            head_next       = '0;
            newt_next       = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            dm1_reg    <= '0;
            tight_reg  <= '0;
            head_reg   <= '0;
            newt_reg   <= '0;
            step_reg   <= '0;
            dig_reg    <= '0;
            last_reg   <= 1'b0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            dm1_reg    <= dm1_next;
            tight_reg  <= tight_next;
            head_reg   <= head_next;
            newt_reg   <= newt_next;
            step_reg   <= step_next;
            dig_reg    <= dig_next;
            last_reg   <= last_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            res0_reg <= '0;
            out_reg  <= '0;
        end else begin
            res0_reg <= res0_next;
            out_reg  <= out_next;
        end
    end

    // Ring of residue cells; the cell at the active end takes the feedback.
    for (genvar k = 0; k < MAX_MODULUS; k++) begin : g_ring
        if (k == MAX_MODULUS - 1) begin : g_tail
            dsr_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ring_ctrl),
                .sel_feed    (dm1_reg == IDX_W'(k)),
                .neighbor_in (feed),
                .feed_in     (feed),
                .count_out   (cell_val[k])
            );
        end else begin : g_body
            dsr_cell u_cell (
                .aclk        (aclk),
                .aresetn     (aresetn),
                .ctrl        (ring_ctrl),
                .sel_feed    (dm1_reg == IDX_W'(k)),
                .neighbor_in (cell_val[k+1]),
                .feed_in     (feed),
                .count_out   (cell_val[k])
            );
        end
    end

    dsr_window u_window (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (win_ctrl),
        .head_val    (head_val),
        .head_tight  (head_reg == tight_reg),
        .digit       (dig_reg),
        .next_val    (next_val),
        .moved_tight (moved_tight)
    );

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {2'b00, out_reg};

    residues_in_ring: assert property (@(posedge aclk) disable iff (!aresetn)
        (tight_reg <= dm1_reg) && (head_reg <= dm1_reg) && (newt_reg <= dm1_reg))
        else $error("residue index beyond the active ring");

    run_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RUN) |-> (step_reg <= STEP_W'(dm1_reg) + STEP_W'(WIN - 1)))
        else $error("digit run overran the ring rotation");

    result_from_finish: assert property (@(posedge aclk) disable iff (!aresetn)
        (mvalid_reg && !$past(mvalid_reg)) |-> $past(state_reg == ST_FINISH && last_reg))
        else $error("result raised outside the end of a bound");

    result_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        mvalid_reg |-> ({2'b00, out_reg} < PRIME))
        else $error("result count out of range");

endmodule
